// ===== rtl/core/uart_rx_byte_with_timeout_core_defines.svh =====
// Assertion macros for the UART receiver core.
// Used by files under rtl/core; expects aclk and aresetn in scope.
`ifndef UART_RX_BYTE_WITH_TIMEOUT_CORE_DEFINES_SVH
`define UART_RX_BYTE_WITH_TIMEOUT_CORE_DEFINES_SVH

// Condition that must hold at every edge outside reset.
`define URX_ASSERT(name, cond, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Trigger at one edge implies consequence at the next edge.
`define URX_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== rtl/core/urxbt_pkg.sv =====
// Shared types and constants for the UART receiver core.
// No dependencies.
package urxbt_pkg;

    localparam int CFG_ADDR_W  = 4;
    localparam int TICK_W      = 13;
    localparam int WAIT_W      = 16;
    localparam int BIT_TICKS_W = 12;
    localparam int CONFIRM_W   = 8;
    localparam int FIRST_W     = 13;
    localparam int BYTE_W      = 8;

    // register indexes (paddr[3:2])
    localparam logic [1:0] REG_BIT_TICKS    = 2'd0;
    localparam logic [1:0] REG_CONFIRM      = 2'd1;
    localparam logic [1:0] REG_FIRST_SAMPLE = 2'd2;

    localparam logic [BIT_TICKS_W-1:0] BIT_TICKS_RST    = 12'd69;
    localparam logic [CONFIRM_W-1:0]   CONFIRM_RST      = 8'd8;
    localparam logic [FIRST_W-1:0]     FIRST_SAMPLE_RST = 13'd96;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TIMEOUT = 2'd1,
        ST_FRAMING = 2'd2
    } status_t;

endpackage

// ===== rtl/core/uart_rx_byte_with_timeout_core.sv =====
// 8N1 UART receiver, one sample tick per input transfer, with idle timeout.
// Depends on urxbt_pkg and uart_rx_byte_with_timeout_core_defines.svh.
//
// Every input transfer is one tick of the sample clock: the rx line level and
// the idle-wait limit. The receiver takes one transfer per clock cycle; the
// tick is handled in the cycle it is accepted and a result (byte with status
// ok, idle timeout or framing error) lands in a two-deep output buffer. Input
// stalls only when both output slots hold unread results. Tick delays come
// from the APB registers bit_ticks (0x0), confirm_ticks (0x4) and
// first_sample_ticks (0x8); a value of 0 acts as 1 and a write applies at the
// next delay load. A wait_limit L >= 2 times out after L-1 idle high ticks;
// 0 and 1 never time out.
`include "uart_rx_byte_with_timeout_core_defines.svh"

module uart_rx_byte_with_timeout_core
    import urxbt_pkg::*;
#(
    parameter int DATA_BITS = 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input ticks
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // [0] line_level, [16:1] wait_limit
    // results
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [BYTE_W-1:0]     m_tdata,   // [7:0] data_byte
    output logic [1:0]            m_tuser,   // [1:0] status
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_CONFIRM,
        PH_DATA,
        PH_STOP
    } phase_t;

    localparam int BITS_W = 4;

    // configuration registers
    logic [BIT_TICKS_W-1:0] bit_ticks_reg;
    logic [CONFIRM_W-1:0]   confirm_ticks_reg;
    logic [FIRST_W-1:0]     first_sample_ticks_reg;

    // receiver state
    phase_t                 phase_reg, phase_next;
    logic [TICK_W-1:0]      tick_reg, tick_next;
    logic [BITS_W-1:0]      bits_left_reg, bits_left_next;
    logic [DATA_BITS-1:0]   shift_reg, shift_next;
    logic [WAIT_W-1:0]      wait_reg, wait_next;
    logic                   wait_loaded_reg, wait_loaded_next;

    // output buffer
    logic                   out_valid_reg;
    logic [BYTE_W-1:0]      out_byte_reg;
    status_t                out_status_reg;
    logic                   skid_valid_reg;
    logic [BYTE_W-1:0]      skid_byte_reg;
    status_t                skid_status_reg;

    logic                   line_high;
    logic [WAIT_W-1:0]      wait_limit;
    logic                   s_accept;
    logic                   m_take;
    logic                   cfg_wr;
    logic                   act;
    logic [WAIT_W-1:0]      wait_base;
    logic [WAIT_W-1:0]      wait_dec;
    logic                   res_valid;
    status_t                res_status;
    logic [BYTE_W-1:0]      res_byte;
    logic [DATA_BITS+BYTE_W-1:0] shift_ext;
    logic [BITS_W-1:0]      bits_dec;

    assign line_high  = s_tdata[0];
    assign wait_limit = s_tdata[WAIT_W:1];
    assign s_tready   = !skid_valid_reg;
    assign s_accept   = s_tvalid && s_tready;
    assign m_take     = out_valid_reg && m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tuser  = out_status_reg;

    // APB
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        prdata = '0;
        unique case (paddr[3:2])
            REG_BIT_TICKS:    prdata = {{(32-BIT_TICKS_W){1'b0}}, bit_ticks_reg};
            REG_CONFIRM:      prdata = {{(32-CONFIRM_W){1'b0}}, confirm_ticks_reg};
            REG_FIRST_SAMPLE: prdata = {{(32-FIRST_W){1'b0}}, first_sample_ticks_reg};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_ticks_reg          <= BIT_TICKS_RST;
            confirm_ticks_reg      <= CONFIRM_RST;
            first_sample_ticks_reg <= FIRST_SAMPLE_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_BIT_TICKS:    bit_ticks_reg          <= pwdata[BIT_TICKS_W-1:0];
                REG_CONFIRM:      confirm_ticks_reg      <= pwdata[CONFIRM_W-1:0];
                REG_FIRST_SAMPLE: first_sample_ticks_reg <= pwdata[FIRST_W-1:0];
                default: ;
            endcase
        end
    end

    // per-tick update
    assign act       = tick_reg <= TICK_W'(1);
    assign wait_base = (phase_reg == PH_IDLE && !wait_loaded_reg) ? wait_limit : wait_reg;
    assign wait_dec  = (wait_base != '0) ? wait_base - WAIT_W'(1) : wait_base;
    assign shift_ext = {{BYTE_W{1'b0}}, shift_reg};
    assign bits_dec  = bits_left_reg - BITS_W'(1);

    always_comb begin
        phase_next       = phase_reg;
        tick_next        = tick_reg;
        bits_left_next   = bits_left_reg;
        shift_next       = shift_reg;
        wait_next        = wait_reg;
        wait_loaded_next = wait_loaded_reg;
        res_valid        = 1'b0;
        res_status       = ST_OK;
        res_byte         = '0;

        unique case (phase_reg)
            PH_IDLE: begin
                wait_loaded_next = 1'b1;
                if (!line_high) begin
                    phase_next = PH_CONFIRM;
                    tick_next  = TICK_W'(confirm_ticks_reg);
                    wait_next  = wait_base;
                end else begin
                    wait_next = wait_dec;
                    if (wait_dec == WAIT_W'(1)) begin
                        wait_loaded_next = 1'b0;
                        res_valid        = 1'b1;
                        res_status       = ST_TIMEOUT;
                    end
                end
            end
            PH_CONFIRM: begin
                if (!act) begin
                    tick_next = tick_reg - TICK_W'(1);
                end else if (!line_high) begin
                    phase_next     = PH_DATA;
                    tick_next      = first_sample_ticks_reg;
                    bits_left_next = BITS_W'(DATA_BITS);
                    shift_next     = '0;
                end else begin
                    // glitch: back to idle, keep the running wait
                    phase_next = PH_IDLE;
                    tick_next  = '0;
                    wait_next  = wait_dec;
                    if (wait_dec == WAIT_W'(1)) begin
                        wait_loaded_next = 1'b0;
                        res_valid        = 1'b1;
                        res_status       = ST_TIMEOUT;
                    end
                end
            end
            PH_DATA: begin
                if (!act) begin
                    tick_next = tick_reg - TICK_W'(1);
                end else begin
                    shift_next     = {line_high, shift_reg[DATA_BITS-1:1]};
                    tick_next      = TICK_W'(bit_ticks_reg);
                    bits_left_next = bits_dec;
                    if (bits_dec == '0) begin
                        phase_next = PH_STOP;
                    end
                end
            end
            PH_STOP: begin
                if (!act) begin
                    tick_next = tick_reg - TICK_W'(1);
                end else begin
                    phase_next       = PH_IDLE;
                    tick_next        = '0;
                    wait_loaded_next = 1'b0;
                    res_valid        = 1'b1;
                    if (line_high) begin
                        res_status = ST_OK;
                        res_byte   = shift_ext[BYTE_W-1:0];
                    end else begin
                        res_status = ST_FRAMING;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_IDLE;
            tick_reg        <= '0;
            bits_left_reg   <= '0;
            shift_reg       <= '0;
            wait_reg        <= '0;
            wait_loaded_reg <= 1'b0;
        end else if (s_accept) begin
            phase_reg       <= phase_next;
            tick_reg        <= tick_next;
            bits_left_reg   <= bits_left_next;
            shift_reg       <= shift_next;
            wait_reg        <= wait_next;
            wait_loaded_reg <= wait_loaded_next;
        end
    end

    // two-slot output buffer; skid slot fills only when the head is stalled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (m_take || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                out_byte_reg   <= skid_byte_reg;
                out_status_reg <= skid_status_reg;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= s_accept && res_valid;
                out_byte_reg   <= res_byte;
                out_status_reg <= res_status;
            end
        end else if (s_accept && res_valid) begin
            skid_valid_reg  <= 1'b1;
            skid_byte_reg   <= res_byte;
            skid_status_reg <= res_status;
        end
    end

    `URX_ASSERT(a_skid_behind_head, !skid_valid_reg || out_valid_reg, "skid full, head empty")
    `URX_ASSERT(a_no_result_in_data, !(s_accept && res_valid) || phase_reg != PH_DATA,
        "result raised while shifting data bits")
    `URX_ASSERT(a_bits_in_range,
        phase_reg != PH_DATA
        || (bits_left_reg != '0 && bits_left_reg <= BITS_W'(DATA_BITS)),
        "bit counter out of range")
    `URX_ASSERT_NEXT(a_stop_to_idle, s_accept && phase_reg == PH_STOP && act,
        phase_reg == PH_IDLE && !wait_loaded_reg, "stop bit did not return to idle")

endmodule
